// File: rtl/swft_pkg.sv
// Package: shared types, constants and the stop word table of the tokenizer
`timescale 1ns / 1ps
package swft_pkg;

	localparam int MAX_STOP_LEN_DEF    = 10;
	localparam int STOP_WORD_COUNT_DEF = 141;
	localparam int TABLE_SIZE          = 141;
	localparam int WORD_CHARS          = 10;
	localparam int WORD_BITS           = WORD_CHARS * 8;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_CHAR,
		EM_HELD,
		EM_MARK
	} emit_sel_t;

	typedef struct packed {
		logic      latch;
		logic      shift;
		emit_sel_t emit;
		logic      held_end;
		logic      k_clr;
		logic      k_inc;
		logic      set_pass;
		logic      clear;
		logic      match;
		logic      reduce;
		logic      fin;
	} ctrl_cmd_t;

	typedef struct packed {
		logic alnum;
		logic space;
		logic eot;
		logic pass;
		logic len_zero;
		logic len_full;
		logic k_last;
		logic stop;
		logic can_emit;
		logic out_free;
		logic pend_valid;
	} dp_stat_t;

	function automatic logic [WORD_BITS-1:0] stop_word(input int i);
		case (i)
			0: return "a";        1: return "an";       2: return "the";
			3: return "i";        4: return "me";       5: return "my";
			6: return "myself";   7: return "we";       8: return "our";
			9: return "ours";     10: return "ourselves";
			11: return "you";     12: return "your";    13: return "yours";
			14: return "yourself"; 15: return "yourselves";
			16: return "he";      17: return "him";     18: return "his";
			19: return "himself"; 20: return "she";     21: return "her";
			22: return "hers";    23: return "herself";
			24: return "it";      25: return "its";     26: return "itself";
			27: return "they";    28: return "them";    29: return "their";
			30: return "theirs";  31: return "themselves";
			32: return "in";      33: return "on";      34: return "at";
			35: return "to";      36: return "for";     37: return "of";
			38: return "with";    39: return "by";      40: return "from";
			41: return "as";      42: return "into";    43: return "through";
			44: return "during";  45: return "before";  46: return "after";
			47: return "above";   48: return "below";   49: return "between";
			50: return "under";   51: return "about";
			52: return "is";      53: return "am";      54: return "are";
			55: return "was";     56: return "were";    57: return "be";
			58: return "been";    59: return "being";
			60: return "have";    61: return "has";     62: return "had";
			63: return "having";
			64: return "do";      65: return "does";    66: return "did";
			67: return "doing";
			68: return "will";    69: return "would";   70: return "shall";
			71: return "should";  72: return "may";     73: return "might";
			74: return "can";     75: return "could";   76: return "must";
			77: return "not";     78: return "no";      79: return "nor";
			80: return "but";     81: return "and";     82: return "or";
			83: return "so";      84: return "if";      85: return "then";
			86: return "than";    87: return "too";     88: return "very";
			89: return "just";    90: return "also";
			91: return "that";    92: return "this";    93: return "these";
			94: return "those";   95: return "which";   96: return "what";
			97: return "who";     98: return "whom";
			99: return "when";    100: return "where";  101: return "why";
			102: return "how";
			103: return "all";    104: return "each";   105: return "every";
			106: return "both";   107: return "few";    108: return "more";
			109: return "most";
			110: return "other";  111: return "some";   112: return "such";
			113: return "only";   114: return "own";    115: return "same";
			116: return "here";   117: return "there";  118: return "again";
			119: return "once";
			120: return "up";     121: return "out";    122: return "off";
			123: return "over";   124: return "down";
			125: return "dont";   126: return "doesnt"; 127: return "didnt";
			128: return "wont";   129: return "wouldnt"; 130: return "cant";
			131: return "couldnt";
			132: return "shouldnt"; 133: return "mustnt"; 134: return "isnt";
			135: return "arent";  136: return "wasnt";  137: return "werent";
			138: return "hasnt";  139: return "havent"; 140: return "hadnt";
			default: return '0;
		endcase
	endfunction

	function automatic int stop_len(input int i);
		logic [WORD_BITS-1:0] w;
		int n;
		w = stop_word(i);
		n = 0;
		for (int k = 0; k < WORD_CHARS; k++) begin
			if (w[8*k +: 8] != 8'd0) n++;
		end
		return n;
	endfunction

endpackage

// File: rtl/swft_if.sv
// Interfaces: byte request channel and token result channel
`timescale 1ns / 1ps
interface swft_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;
	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface swft_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_char;
	logic       char_present;
	logic       token_end;
	logic       run_last;
	modport source (output valid, output token_char, output char_present,
		output token_end, output run_last, input ready);
	modport sink (input valid, input token_char, input char_present,
		input token_end, input run_last, output ready);
endinterface

// File: rtl/stop_word_filtering_tokenizer_top.sv
// Top level: stop word filtering tokenizer
`timescale 1ns / 1ps
// Takes one text byte per request and gives one character or end marker per result,
// with run_last on the final result of each byte. Requests are taken one at a time:
// a byte that is held, dropped or passed through goes through classify, the end of
// text check and the finish before the next request. Closing a held token adds the
// close, the two-stage registered stop word match and the decision, then one result
// per character flushed; closing a long token or an empty one adds only the close. A
// token that grows past MAX_STOP_LEN flushes its held characters, then the new one.
// A byte that closes on whitespace and also carries end_of_text walks the close twice.
// Output stalls hold the sequence whenever the result register cannot advance.
// One result is held back in a pending register so that run_last can be set on it
// once the byte is done.
module stop_word_filtering_tokenizer_top #(
	parameter int MAX_STOP_LEN    = swft_pkg::MAX_STOP_LEN_DEF,
	parameter int STOP_WORD_COUNT = swft_pkg::STOP_WORD_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	swft_in_if.sink   text_in,
	swft_out_if.source token_out
);
	import swft_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	swft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_in.valid),
		.in_ready (text_in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	swft_datapath #(
		.MAX_STOP_LEN    (MAX_STOP_LEN),
		.STOP_WORD_COUNT (STOP_WORD_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.text_byte    (text_in.text_byte),
		.end_of_text  (text_in.end_of_text),
		.out_valid    (token_out.valid),
		.out_ready    (token_out.ready),
		.token_char   (token_out.token_char),
		.char_present (token_out.char_present),
		.token_end    (token_out.token_end),
		.run_last     (token_out.run_last)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		text_in.valid && text_in.ready |=> !text_in.ready)
		else $error("request taken while previous byte still in work");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		token_out.valid && !token_out.char_present |->
			token_out.token_end && token_out.token_char == 8'd0)
		else $error("bare end marker malformed");

	a_emit_gated: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit != EM_NONE |-> stat.can_emit)
		else $error("result produced with no room");

endmodule

// File: rtl/swft_ctrl.sv
// Controller: sequences one byte request through classify, flush, match and close
`timescale 1ns / 1ps
module swft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swft_pkg::dp_stat_t  stat,
	output swft_pkg::ctrl_cmd_t cmd
);
	import swft_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHAR,
		ST_FLUSH_LONG,
		ST_EMIT_C,
		ST_CLOSE,
		ST_MATCH,
		ST_REDUCE,
		ST_DECIDE,
		ST_FLUSH_KEEP,
		ST_EOT,
		ST_FIN
	} state_t;

	state_t state_q, state_d, after_close;
	logic   from_eot_q, from_eot_d;

	always_comb begin
		cmd         = '0;
		cmd.emit    = EM_NONE;
		state_d     = state_q;
		from_eot_d  = from_eot_q;
		in_ready    = 1'b0;
		after_close = from_eot_q ? ST_FIN : ST_EOT;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_CHAR;
				end
			end
			ST_CHAR: begin
				if (stat.alnum) begin
					if (stat.pass) begin
						if (stat.can_emit) begin
							cmd.emit = EM_CHAR;
							state_d  = ST_EOT;
						end
					end else if (!stat.len_full) begin
						cmd.shift = 1'b1;
						state_d   = ST_EOT;
					end else begin
						cmd.k_clr = 1'b1;
						state_d   = ST_FLUSH_LONG;
					end
				end else if (stat.space) begin
					from_eot_d = 1'b0;
					state_d    = ST_CLOSE;
				end else begin
					state_d = ST_EOT;
				end
			end
			ST_FLUSH_LONG: begin
				if (stat.can_emit) begin
					cmd.emit  = EM_HELD;
					cmd.k_inc = 1'b1;
					if (stat.k_last) state_d = ST_EMIT_C;
				end
			end
			ST_EMIT_C: begin
				if (stat.can_emit) begin
					cmd.emit     = EM_CHAR;
					cmd.set_pass = 1'b1;
					state_d      = ST_EOT;
				end
			end
			ST_CLOSE: begin
				if (stat.pass) begin
					if (stat.can_emit) begin
						cmd.emit  = EM_MARK;
						cmd.clear = 1'b1;
						state_d   = after_close;
					end
				end else if (stat.len_zero) begin
					state_d = after_close;
				end else begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_REDUCE;
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				state_d    = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.stop) begin
					cmd.clear = 1'b1;
					state_d   = after_close;
				end else begin
					cmd.k_clr = 1'b1;
					state_d   = ST_FLUSH_KEEP;
				end
			end
			ST_FLUSH_KEEP: begin
				if (stat.can_emit) begin
					cmd.emit     = EM_HELD;
					cmd.held_end = stat.k_last;
					cmd.k_inc    = 1'b1;
					if (stat.k_last) begin
						cmd.clear = 1'b1;
						state_d   = after_close;
					end
				end
			end
			ST_EOT: begin
				if (stat.eot) begin
					from_eot_d = 1'b1;
					state_d    = ST_CLOSE;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!stat.pend_valid) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			from_eot_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			from_eot_q <= from_eot_d;
		end
	end

endmodule

// File: rtl/swft_datapath.sv
// Datapath: held token, stop word match, pending result and output register
`timescale 1ns / 1ps
module swft_datapath #(
	parameter int MAX_STOP_LEN    = swft_pkg::MAX_STOP_LEN_DEF,
	parameter int STOP_WORD_COUNT = swft_pkg::STOP_WORD_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  swft_pkg::ctrl_cmd_t cmd,
	output swft_pkg::dp_stat_t  stat,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          token_char,
	output logic                char_present,
	output logic                token_end,
	output logic                run_last
);
	import swft_pkg::*;

	localparam int LW = $clog2(MAX_STOP_LEN + 1);
	localparam int KW = (MAX_STOP_LEN > 1) ? $clog2(MAX_STOP_LEN) : 1;

	logic [7:0]                   c_q;
	logic                         alnum_q, space_q, eot_q;
	logic [MAX_STOP_LEN-1:0][7:0] tok_q;
	logic [LW-1:0]                len_q;
	logic                         pass_q;
	logic [KW-1:0]                k_q;
	logic [STOP_WORD_COUNT-1:0]   hit_c, hit_s1;
	logic                         stop_q;

	logic [7:0] low_c;
	logic       pend_v_q, out_v_q;
	logic [7:0] pend_char_q, out_char_q;
	logic       pend_pres_q, pend_end_q, out_pres_q, out_end_q, out_last_q;

	logic [LW-1:0] idx;
	logic [7:0]    held_char;
	logic          emit_valid;
	logic [7:0]    new_char;
	logic          new_pres, new_end;

	assign low_c = (text_byte >= "A" && text_byte <= "Z") ? text_byte + 8'd32 : text_byte;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			c_q     <= low_c;
			alnum_q <= (low_c >= "a" && low_c <= "z") || (low_c >= "0" && low_c <= "9");
			space_q <= (low_c >= 8'd9 && low_c <= 8'd13) || low_c == 8'd32;
			eot_q   <= end_of_text;
		end
		if (cmd.shift) begin
			for (int j = MAX_STOP_LEN - 1; j > 0; j--) tok_q[j] <= tok_q[j-1];
			tok_q[0] <= c_q;
		end
		if (cmd.k_clr) k_q <= '0;
		else if (cmd.k_inc) k_q <= k_q + 1'b1;
		if (cmd.match) hit_s1 <= hit_c;
		if (cmd.reduce) stop_q <= |hit_s1;
	end

	for (genvar gi = 0; gi < STOP_WORD_COUNT; gi++) begin : g_word
		localparam logic [WORD_BITS-1:0] LIT = stop_word(gi);
		localparam int WL = stop_len(gi);
		if (gi < TABLE_SIZE && WL <= MAX_STOP_LEN) begin : g_cmp
			logic [MAX_STOP_LEN-1:0] byte_eq;
			for (genvar gj = 0; gj < MAX_STOP_LEN; gj++) begin : g_byte
				if (gj < WL) begin : g_on
					assign byte_eq[gj] = tok_q[gj] == LIT[8*gj +: 8];
				end else begin : g_off
					assign byte_eq[gj] = 1'b1;
				end
			end
			assign hit_c[gi] = (len_q == LW'(WL)) && (&byte_eq);
		end else begin : g_none
			assign hit_c[gi] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			pass_q <= 1'b0;
		end else if (cmd.clear) begin
			len_q  <= '0;
			pass_q <= 1'b0;
		end else if (cmd.set_pass) begin
			len_q  <= '0;
			pass_q <= 1'b1;
		end else if (cmd.shift) begin
			len_q <= len_q + 1'b1;
		end
	end

	assign idx       = len_q - LW'(1) - LW'(k_q);
	assign held_char = tok_q[idx[KW-1:0]];

	always_comb begin
		emit_valid = cmd.emit != EM_NONE;
		new_char   = 8'd0;
		new_pres   = 1'b0;
		new_end    = 1'b0;
		case (cmd.emit)
			EM_CHAR: begin
				new_char = c_q;
				new_pres = 1'b1;
			end
			EM_HELD: begin
				new_char = held_char;
				new_pres = 1'b1;
				new_end  = cmd.held_end;
			end
			EM_MARK: new_end = 1'b1;
			default: new_char = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit_valid) pend_v_q <= 1'b1;
			else if (cmd.fin) pend_v_q <= 1'b0;
			if ((emit_valid && pend_v_q) || cmd.fin) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			pend_char_q <= new_char;
			pend_pres_q <= new_pres;
			pend_end_q  <= new_end;
		end
		if ((emit_valid && pend_v_q) || cmd.fin) begin
			out_char_q <= pend_char_q;
			out_pres_q <= pend_pres_q;
			out_end_q  <= pend_end_q;
			out_last_q <= cmd.fin;
		end
	end

	assign out_valid    = out_v_q;
	assign token_char   = out_char_q;
	assign char_present = out_pres_q;
	assign token_end    = out_end_q;
	assign run_last     = out_last_q;

	always_comb begin
		stat            = '0;
		stat.alnum      = alnum_q;
		stat.space      = space_q;
		stat.eot        = eot_q;
		stat.pass       = pass_q;
		stat.len_zero   = len_q == '0;
		stat.len_full   = len_q == LW'(MAX_STOP_LEN);
		stat.k_last     = LW'(k_q) == len_q - LW'(1);
		stat.stop       = stop_q;
		stat.out_free   = !out_v_q || out_ready;
		stat.can_emit   = !pend_v_q || !out_v_q || out_ready;
		stat.pend_valid = pend_v_q;
	end

endmodule
